// ===== rtl/ept_pkg.sv =====
// Package: pose and transform types, CORDIC constants for the Euler pose transform.
package ept_pkg;

	localparam int ATAN_ENTRIES = 20;
	localparam int ANG_W        = 33;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [31:0] t0;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [31:0] t1;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
		logic signed [31:0] t2;
	} xform_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
		logic [31:0] v;
		begin
			v = 32'h0;
			unique case (i)
				0:  v = 32'h20000000;
				1:  v = 32'h12E4051E;
				2:  v = 32'h09FB385B;
				3:  v = 32'h051111D4;
				4:  v = 32'h028B0D43;
				5:  v = 32'h0145D7E1;
				6:  v = 32'h00A2F61E;
				7:  v = 32'h00517C55;
				8:  v = 32'h0028BE53;
				9:  v = 32'h00145F2F;
				10: v = 32'h000A2F98;
				11: v = 32'h000517CC;
				12: v = 32'h00028BE6;
				13: v = 32'h000145F3;
				14: v = 32'h0000A2FA;
				15: v = 32'h0000517D;
				16: v = 32'h000028BE;
				17: v = 32'h0000145F;
				18: v = 32'h00000A30;
				19: v = 32'h00000518;
				default: v = 32'h0;
			endcase
			return $signed({1'b0, v});
		end
	endfunction

endpackage

// ===== rtl/euler_pose_to_transform_unit.sv =====
// Top level: Euler Z-Y-X pose to the top three rows of a homogeneous transform.
// Usage:
//   Drive pose and raise start; the pose transfers at a clock edge where start is
//   high and busy is low. busy is tied low: a new pose may enter every cycle.
//   Each result appears on xform for exactly one cycle with done high and
//   transfers at the edge that ends that cycle; the receiver cannot stall.
//   Path: the angle-fold register loads at the transfer edge, then one stage per
//   CORDIC step, three matrix stages and one output register, after which done
//   rises; the result transfers at the edge that ends its done cycle. CORDIC_STEPS
//   is capped at 20.
//   Throughput: one pose per cycle.
//   The three angles share no hardware: three CORDIC pipelines run in parallel.
//   Translations ride a delay line alongside the rotation pipeline.
//   Reset clears all valid bits; poses in flight are dropped.
//   Results leave in the order poses entered.
module euler_pose_to_transform_unit import ept_pkg::*; #(
	parameter int CORDIC_STEPS = 14,
	parameter int FRAC_BITS    = 14
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  pose_t  pose,
	output logic   done,
	output xform_t xform
);
	localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int DLY   = STEPS + 4;
	localparam int W     = FRAC_BITS + 3;

	logic               go;
	logic [2:0]         cv;
	logic signed [W-1:0] sx, cx, sy, cy, sz, cz;
	logic               m_vld;
	logic signed [15:0] rot [9];
	logic signed [31:0] tx_q [DLY], ty_q [DLY], tz_q [DLY];
	logic               done_q;
	xform_t             xform_q;

	assign busy = 1'b0;
	assign go   = start && !busy;

	ept_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_roll (
		.clk, .arst_n, .in_vld(go), .angle(pose.roll_angle),
		.out_vld(cv[0]), .sin_o(sx), .cos_o(cx));
	ept_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_pitch (
		.clk, .arst_n, .in_vld(go), .angle(pose.pitch_angle),
		.out_vld(cv[1]), .sin_o(sy), .cos_o(cy));
	ept_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_yaw (
		.clk, .arst_n, .in_vld(go), .angle(pose.yaw_angle),
		.out_vld(cv[2]), .sin_o(sz), .cos_o(cz));

	ept_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
		.clk, .arst_n, .in_vld(&cv),
		.sx, .cx, .sy, .cy, .sz, .cz,
		.out_vld(m_vld), .rot);

	always_ff @(posedge clk) begin
		tx_q[0] <= pose.pos_x;
		ty_q[0] <= pose.pos_y;
		tz_q[0] <= pose.pos_z;
		for (int k = 1; k < DLY; k++) begin
			tx_q[k] <= tx_q[k-1];
			ty_q[k] <= ty_q[k-1];
			tz_q[k] <= tz_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= m_vld;
		end
	end

	always_ff @(posedge clk) begin
		xform_q.r00 <= rot[0];
		xform_q.r01 <= rot[1];
		xform_q.r02 <= rot[2];
		xform_q.t0  <= tx_q[DLY-1];
		xform_q.r10 <= rot[3];
		xform_q.r11 <= rot[4];
		xform_q.r12 <= rot[5];
		xform_q.t1  <= ty_q[DLY-1];
		xform_q.r20 <= rot[6];
		xform_q.r21 <= rot[7];
		xform_q.r22 <= rot[8];
		xform_q.t2  <= tz_q[DLY-1];
	end

	assign done  = done_q;
	assign xform = xform_q;
endmodule

// ===== rtl/ept_cordic.sv =====
// Pipelined CORDIC: one rotation step per register stage, sine and cosine of a binary angle.
module ept_cordic import ept_pkg::*; #(
	parameter int CORDIC_STEPS = 14,
	parameter int FRAC_BITS    = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic signed [15:0]         angle,
	output logic                       out_vld,
	output logic signed [FRAC_BITS+2:0] sin_o,
	output logic signed [FRAC_BITS+2:0] cos_o
);
	localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int W     = FRAC_BITS + 3;
	localparam logic [31:0] GAIN = 32'h26DD3B6A;
	localparam logic [31:0] X0 =
		(GAIN + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

	logic signed [W-1:0]     x_s   [STEPS+1];
	logic signed [W-1:0]     y_s   [STEPS+1];
	logic signed [ANG_W-1:0] z_s   [STEPS+1];
	logic                    flip_s[STEPS+1];
	logic                    vld_s [STEPS+1];

	logic signed [ANG_W-1:0] z_in;
	logic signed [ANG_W-1:0] z_adj;
	logic                    flip_in;
	localparam logic signed [ANG_W-1:0] QTR  = ANG_W'(64'sd1 << 30);
	localparam logic signed [ANG_W-1:0] HALF = ANG_W'(64'sd1 << 31);

	always_comb begin
		z_in    = ANG_W'($signed({angle, 16'h0}));
		z_adj   = z_in;
		flip_in = 1'b0;
		if (z_in > QTR) begin
			z_adj   = z_in - HALF;
			flip_in = 1'b1;
		end else if (z_in < -QTR) begin
			z_adj   = z_in + HALF;
			flip_in = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= W'($signed({1'b0, X0}));
		y_s[0]    <= '0;
		z_s[0]    <= z_adj;
		flip_s[0] <= flip_in;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (!z_s[i][ANG_W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_entry(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_entry(i);
			end
		end
	end

	assign out_vld = vld_s[STEPS];
	assign cos_o   = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign sin_o   = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
endmodule

// ===== rtl/ept_matrix.sv =====
// Rotation matrix pipeline: products of sines and cosines, sum, round and clamp to Q2.14.
module ept_matrix import ept_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic signed [FRAC_BITS+2:0] sx,
	input  logic signed [FRAC_BITS+2:0] cx,
	input  logic signed [FRAC_BITS+2:0] sy,
	input  logic signed [FRAC_BITS+2:0] cy,
	input  logic signed [FRAC_BITS+2:0] sz,
	input  logic signed [FRAC_BITS+2:0] cz,
	output logic                        out_vld,
	output logic signed [15:0]          rot [9]
);
	localparam int W  = FRAC_BITS + 3;
	localparam int P2 = 2 * W;
	localparam int P3 = 3 * W + 2;
	localparam int SH = 3 * FRAC_BITS - 14;

	logic signed [P2-1:0] czsx_s1, cxcz_s1, cxsy_s1, sxsz_s1, cysz_s1, cycz_s1;
	logic signed [P2-1:0] cysx_s1, cxcy_s1, sxsy_s1, cxsz_s1, czsx2_s1;
	logic signed [W-1:0]  sy_s1, sz_s1;
	logic                 vld_s1, vld_s2, vld_s3;

	logic signed [P3-1:0] e_s2 [9];
	logic signed [15:0]   rot_s3 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		czsx_s1  <= P2'(cz) * P2'(sx);
		cxcz_s1  <= P2'(cx) * P2'(cz);
		cxsy_s1  <= P2'(cx) * P2'(sy);
		sxsz_s1  <= P2'(sx) * P2'(sz);
		cysz_s1  <= P2'(cy) * P2'(sz);
		cycz_s1  <= P2'(cy) * P2'(cz);
		cysx_s1  <= P2'(cy) * P2'(sx);
		cxcy_s1  <= P2'(cx) * P2'(cy);
		sxsy_s1  <= P2'(sx) * P2'(sy);
		cxsz_s1  <= P2'(cx) * P2'(sz);
		czsx2_s1 <= P2'(cz) * P2'(sx);
		sy_s1    <= sy;
		sz_s1    <= sz;
	end

	function automatic logic signed [P3-1:0] up(input logic signed [P2-1:0] p);
		return P3'(p) <<< FRAC_BITS;
	endfunction

	always_ff @(posedge clk) begin
		e_s2[0] <= up(cycz_s1);
		e_s2[1] <= P3'(czsx_s1) * P3'(sy_s1) - up(cxsz_s1);
		e_s2[2] <= P3'(cxcz_s1) * P3'(sy_s1) + up(sxsz_s1);
		e_s2[3] <= up(cysz_s1);
		e_s2[4] <= up(cxcz_s1) + P3'(sxsy_s1) * P3'(sz_s1);
		e_s2[5] <= P3'(cxsy_s1) * P3'(sz_s1) - up(czsx2_s1);
		e_s2[6] <= -(P3'(sy_s1) <<< (2 * FRAC_BITS));
		e_s2[7] <= up(cysx_s1);
		e_s2[8] <= up(cxcy_s1);
	end

	function automatic logic signed [15:0] to_q14(input logic signed [P3-1:0] v);
		logic signed [P3-1:0] r;
		begin
			r = (v + (P3'(1) <<< (SH - 1))) >>> SH;
			if (r > P3'(16384))       return 16'sd16384;
			else if (r < -P3'(16384)) return -16'sd16384;
			else                      return r[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			rot_s3[k] <= to_q14(e_s2[k]);
		end
	end

	assign out_vld = vld_s3;
	assign rot     = rot_s3;
endmodule
